// File: src/bsf_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the allocation bitmap block.
// No dependencies; used by every other file in src.
package bsf_pkg;

	// Command modes as they arrive in the mode field (code seven is unused)
	localparam logic [2:0] MODE_TEST      = 3'd0;
	localparam logic [2:0] MODE_SET_BIT   = 3'd1;
	localparam logic [2:0] MODE_CLR_BIT   = 3'd2;
	localparam logic [2:0] MODE_SET_RNG   = 3'd3;
	localparam logic [2:0] MODE_CLR_RNG   = 3'd4;
	localparam logic [2:0] MODE_FIND_ZERO = 3'd5;
	localparam logic [2:0] MODE_FIND_ONE  = 3'd6;

	typedef struct packed {
		logic [2:0]  mode;
		logic [11:0] position;
		logic [12:0] count;
	} cmd_t;

	typedef struct packed {
		logic        bit_value;
		logic        found;
		logic [11:0] found_position;
	} rsp_t;

	// Write action of the word unit on the masked bits
	typedef enum logic [1:0] {
		WOP_KEEP,
		WOP_SET,
		WOP_CLEAR
	} wop_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_BASE,
		ST_FETCH,
		ST_WALK,
		ST_DONE
	} state_t;

	// Controller status towards the top level
	typedef struct packed {
		logic idle;
		logic done;
	} ctrl_stat_t;

endpackage

// File: src/bsf_word_unit.sv
`timescale 1ns / 1ps
// Shared word unit: range mask, set/clear of the masked bits, find-first match.
// Depends on bsf_pkg.
module bsf_word_unit #(
	parameter int WORD_BITS = 64,
	localparam int LW  = $clog2(WORD_BITS + 1),
	localparam int IXW = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0] word,
	input  logic [LW-1:0]        lo,
	input  logic [LW-1:0]        hi,
	input  bsf_pkg::wop_t        wr_op,
	input  logic                 match_one,
	output logic [WORD_BITS-1:0] new_word,
	output logic                 hit,
	output logic [IXW-1:0]       hit_idx
);

	logic [WORD_BITS-1:0] in_rng;

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			in_rng[j] = (LW'(j) >= lo) && (LW'(j) < hi);
		end
	end

	always_comb begin
		unique case (wr_op)
			bsf_pkg::WOP_SET:   new_word = word | in_rng;
			bsf_pkg::WOP_CLEAR: new_word = word & ~in_rng;
			default:            new_word = word;
		endcase
	end

	// Scan downwards so the lowest matching bit wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (in_rng[j] && (word[j] == match_one)) begin
				hit     = 1'b1;
				hit_idx = IXW'(j);
			end
		end
	end

endmodule

// File: src/bsf_ctrl.sv
`timescale 1ns / 1ps
// Sequencer, bitmap memory and word walk for the allocation bitmap.
// Depends on bsf_pkg and bsf_word_unit.
module bsf_ctrl #(
	parameter int NUM_WORDS = 64,
	parameter int WORD_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bsf_pkg::cmd_t       cmd,
	input  logic                cmd_take,
	input  logic                res_take,
	output bsf_pkg::rsp_t       rsp,
	output bsf_pkg::ctrl_stat_t stat
);

	localparam int TOTAL = NUM_WORDS * WORD_BITS;
	localparam int IW    = $clog2(TOTAL + 8192);
	localparam int AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int LW    = $clog2(WORD_BITS + 1);
	localparam int IXW   = $clog2(WORD_BITS);
	// Reciprocal for position / WORD_BITS, exact for 12-bit positions
	localparam int DK    = 24;
	localparam int PW    = DK + 12;
	localparam int RECIP = (2 ** DK + WORD_BITS - 1) / WORD_BITS;

	bsf_pkg::state_t state_q, state_d;

	logic [AW-1:0]        clr_q;
	logic [2:0]           mode_q;
	logic [IW-1:0]        pos_q, end_q, base_q;
	logic [11:0]          quo_q;
	logic [AW-1:0]        word_q;
	bsf_pkg::rsp_t        res_q;
	logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	logic [WORD_BITS-1:0] mem_wdata;

	logic [12:0]          ecnt;
	logic [IW-1:0]        pos_ext, end_raw, end_clip;
	logic                 empty;
	logic [PW-1:0]        prod;

	logic [IW-1:0]        base_next;
	logic [LW-1:0]        lo, hi;
	bsf_pkg::wop_t        wop;
	logic                 match_one, is_find, walk_end;
	logic [WORD_BITS-1:0] new_word;
	logic                 hit;
	logic [IXW-1:0]       hit_idx;

	// Command decode at transfer time
	always_comb begin
		unique case (cmd.mode) inside
			bsf_pkg::MODE_TEST, bsf_pkg::MODE_SET_BIT, bsf_pkg::MODE_CLR_BIT:
				ecnt = 13'd1;
			bsf_pkg::MODE_SET_RNG, bsf_pkg::MODE_CLR_RNG,
			bsf_pkg::MODE_FIND_ZERO, bsf_pkg::MODE_FIND_ONE:
				ecnt = cmd.count;
			default:
				ecnt = '0;
		endcase
		pos_ext  = IW'(cmd.position);
		end_raw  = pos_ext + IW'(ecnt);
		end_clip = (end_raw > IW'(TOTAL)) ? IW'(TOTAL) : end_raw;
		empty    = (pos_ext >= IW'(TOTAL)) || (ecnt == '0);
	end

	assign prod = PW'(pos_q[11:0]) * PW'(RECIP);

	// Per-word bounds of the active range
	always_comb begin
		base_next = base_q + IW'(WORD_BITS);
		lo        = (pos_q > base_q) ? LW'(pos_q - base_q) : '0;
		hi        = (end_q >= base_next) ? LW'(WORD_BITS) : LW'(end_q - base_q);
		unique case (mode_q) inside
			bsf_pkg::MODE_SET_BIT, bsf_pkg::MODE_SET_RNG: wop = bsf_pkg::WOP_SET;
			bsf_pkg::MODE_CLR_BIT, bsf_pkg::MODE_CLR_RNG: wop = bsf_pkg::WOP_CLEAR;
			default:                                      wop = bsf_pkg::WOP_KEEP;
		endcase
		match_one = (mode_q != bsf_pkg::MODE_FIND_ZERO);
		is_find   = (mode_q == bsf_pkg::MODE_FIND_ZERO) || (mode_q == bsf_pkg::MODE_FIND_ONE);
		walk_end  = (is_find && hit) || (end_q <= base_next);
	end

	bsf_word_unit #(
		.WORD_BITS(WORD_BITS)
	) u_word (
		.word     (rdata_q),
		.lo       (lo),
		.hi       (hi),
		.wr_op    (wop),
		.match_one(match_one),
		.new_word (new_word),
		.hit      (hit),
		.hit_idx  (hit_idx)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsf_pkg::ST_CLEAR: if (clr_q == AW'(NUM_WORDS - 1)) state_d = bsf_pkg::ST_IDLE;
			bsf_pkg::ST_IDLE: begin
				if (cmd_take) state_d = empty ? bsf_pkg::ST_DONE : bsf_pkg::ST_DIV;
			end
			bsf_pkg::ST_DIV:   state_d = bsf_pkg::ST_BASE;
			bsf_pkg::ST_BASE:  state_d = bsf_pkg::ST_FETCH;
			bsf_pkg::ST_FETCH: state_d = bsf_pkg::ST_WALK;
			bsf_pkg::ST_WALK:  if (walk_end) state_d = bsf_pkg::ST_DONE;
			bsf_pkg::ST_DONE:  if (res_take) state_d = bsf_pkg::ST_IDLE;
			default:           state_d = bsf_pkg::ST_IDLE;
		endcase
	end

	// Memory port controls
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = word_q;
		mem_wdata = new_word;
		mem_raddr = word_q;
		unique case (state_q)
			bsf_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			bsf_pkg::ST_WALK: begin
				mem_we    = (wop != bsf_pkg::WOP_KEEP);
				mem_raddr = word_q + AW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsf_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bsf_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bsf_pkg::ST_IDLE: begin
				if (cmd_take) begin
					mode_q <= cmd.mode;
					pos_q  <= pos_ext;
					end_q  <= end_clip;
					res_q  <= '0;
				end
			end
			bsf_pkg::ST_DIV: quo_q <= prod[DK +: 12];
			bsf_pkg::ST_BASE: begin
				word_q <= quo_q[AW-1:0];
				base_q <= IW'(quo_q) * IW'(WORD_BITS);
			end
			bsf_pkg::ST_WALK: begin
				if (walk_end) begin
					res_q.bit_value      <= (mode_q == bsf_pkg::MODE_TEST) && hit;
					res_q.found          <= is_find && hit;
					res_q.found_position <= (is_find && hit) ? 12'(base_q + IW'(hit_idx)) : '0;
				end else begin
					word_q <= word_q + AW'(1);
					base_q <= base_next;
				end
			end
			default: ;
		endcase
	end

	assign rsp       = res_q;
	assign stat.idle = (state_q == bsf_pkg::ST_IDLE);
	assign stat.done = (state_q == bsf_pkg::ST_DONE);

endmodule

// File: src/bitmap_set_clear_find_first_top.sv
`timescale 1ns / 1ps
// Top level of the allocation bitmap: handshakes and the result register.
// Depends on bsf_pkg and bsf_ctrl.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+--------------------------------
//   in       | in        | in_valid / in_ready   | in_data  (mode, position, count)
//   out      | out       | out_valid / out_ready | out_data (bit_value, found, found_position)
//
// A command passes setup (transfer, position-to-word multiply, base multiply,
// first word read), then walks the bitmap words it touches one word per cycle
// through the single word unit, then hands over the result from the done state.
// An empty command goes from the transfer straight to the hand-over.
// After reset a clearing pass zeroes the bitmap one word a cycle with in_ready low.
// in_ready is high only while the sequencer is idle; a held result in the output
// register stalls the next command only at its hand-over.
module bitmap_set_clear_find_first_top #(
	parameter int NUM_WORDS = 64,
	parameter int WORD_BITS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bsf_pkg::cmd_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output bsf_pkg::rsp_t out_data
);

	bsf_pkg::ctrl_stat_t stat;
	bsf_pkg::rsp_t       rsp;
	logic                cmd_take;
	logic                res_take;
	logic                out_valid_q;
	bsf_pkg::rsp_t       out_data_q;

	// Take a command only while the sequencer is idle
	assign in_ready = stat.idle;
	assign cmd_take = in_valid && in_ready;

	// Output register is free when empty or draining this cycle
	assign res_take = !out_valid_q || out_ready;

	bsf_ctrl #(
		.NUM_WORDS(NUM_WORDS),
		.WORD_BITS(WORD_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (in_data),
		.cmd_take(cmd_take),
		.res_take(res_take),
		.rsp     (rsp),
		.stat    (stat)
	);

	// Hold the result until its transfer; load a new one when the slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done && res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && res_take) begin
			out_data_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
